### hw/rtl/interval_map_table_assert.svh
// assertion macros for the interval map table
`ifndef INTERVAL_MAP_TABLE_ASSERT_SVH
`define INTERVAL_MAP_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define IMT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define IMT_ASSERT_IMPL(label, clk, rst_n, pre, post)
`define IMT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/imt_pkg.sv
// package with types and constants of the interval map table
`default_nettype none
package imt_pkg;
    localparam int Depth = 16;
    localparam int KeyW = 32;
    localparam int ValW = 16;
    localparam int IdxW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam int TmpN = Depth + 2;

    localparam logic [1:0] StDone  = 2'd0;
    localparam logic [1:0] StEmpty = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;

    localparam logic CmdAssign = 1'b0;
    localparam logic CmdLookup = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_BUILD, S_COMMIT, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic build;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic is_lookup;
        logic empty;
        logic scan_done;
    } t_sts;
endpackage
`default_nettype wire

### hw/rtl/imt_ctrl.sv
// controller state machine of the interval map table
`default_nettype none
`include "interval_map_table_assert.svh"
module imt_ctrl import imt_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_fire,
    input  wire  i_out_fire,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_BUILD;
                end
            end
            S_BUILD: begin
                if (i_sts.is_lookup || i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.build = 1'b1;
                    if (i_sts.scan_done) n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `IMT_ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `IMT_ASSERT_NEXT(a_load_build, i_clk, i_rst_n, o_cmd.load, r_state == S_BUILD)
    `IMT_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, o_cmd.commit, o_out_valid)
endmodule
`default_nettype wire

### hw/rtl/imt_dp.sv
// datapath of the interval map table: table, scratch table and lookup
`default_nettype none
module imt_dp import imt_pkg::*; (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  t_cmd             i_cmd,
    input  wire              i_cfg_we,
    input  wire [ValW-1:0]   i_cfg_data,
    input  wire              i_command,
    input  wire [KeyW-1:0]   i_key_begin,
    input  wire [KeyW-1:0]   i_key_end,
    input  wire [ValW-1:0]   i_new_value,
    output t_sts             o_sts,
    output logic [ValW-1:0]  o_lookup_value,
    output logic [1:0]       o_status,
    output logic [CntW-1:0]  o_entry_count
);
    localparam int TCntW = $clog2(TmpN + 1);
    localparam int PhW = $clog2(Depth + 3);

    logic [KeyW-1:0] r_keys [Depth];
    logic [ValW-1:0] r_vals [Depth];
    logic [KeyW-1:0] r_tk [Depth];
    logic [ValW-1:0] r_tv [Depth];
    logic [CntW-1:0] r_used;
    logic [ValW-1:0] r_default;
    logic            r_cmd;
    logic [KeyW-1:0] r_kb, r_ke;
    logic [ValW-1:0] r_nv;
    logic [ValW-1:0] r_last;
    logic [ValW-1:0] r_prev;
    logic [TCntW-1:0] r_n;
    logic [PhW-1:0]  r_ph;
    logic [1:0]      r_phase;
    logic [ValW-1:0] r_res;
    logic [1:0]      r_stat;

    // value in force at a key, priority scan over stored entries
    function automatic logic [ValW-1:0] value_at(
        input logic [KeyW-1:0] key,
        input logic [KeyW-1:0] ks [Depth],
        input logic [ValW-1:0] vs [Depth],
        input logic [CntW-1:0] used,
        input logic [ValW-1:0] dflt);
        logic [ValW-1:0] v;
        v = dflt;
        for (int i = 0; i < Depth; i++) begin
            if (CntW'(i) < used && ks[i] <= key) v = vs[i];
        end
        return v;
    endfunction

    // candidate fed to the canonical builder this cycle
    logic            c_vld;
    logic [KeyW-1:0] c_key;
    logic [ValW-1:0] c_val;
    logic [IdxW-1:0] c_idx;

    always_comb begin
        c_vld = 1'b0;
        c_key = r_kb;
        c_val = r_nv;
        c_idx = r_ph[IdxW-1:0];
        unique case (r_phase)
            2'd0: begin
                c_vld = (CntW'(r_ph) < r_used) && (r_keys[c_idx] < r_kb);
                c_key = r_keys[c_idx];
                c_val = r_vals[c_idx];
            end
            2'd1: begin
                c_vld = 1'b1;
                c_key = r_kb;
                c_val = r_nv;
            end
            2'd2: begin
                c_vld = 1'b1;
                c_key = r_ke;
                c_val = r_last;
            end
            default: begin
                c_vld = (CntW'(r_ph) < r_used) && (r_keys[c_idx] > r_ke);
                c_key = r_keys[c_idx];
                c_val = r_vals[c_idx];
            end
        endcase
    end

    wire last_ph = (r_phase == 2'd0 || r_phase == 2'd3)
                   ? (PhW'(Depth - 1) == r_ph) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_default <= '0;
        end else begin
            if (i_cfg_we) r_default <= i_cfg_data;
            if (i_cmd.commit && r_n <= TCntW'(Depth)) begin
                r_used <= CntW'(r_n);
                for (int i = 0; i < Depth; i++) begin
                    r_keys[i] <= r_tk[i];
                    r_vals[i] <= r_tv[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_kb <= i_key_begin;
            r_ke <= i_key_end;
            r_nv <= i_new_value;
            r_last <= value_at(i_key_end, r_keys, r_vals, r_used, r_default);
            r_res <= value_at(i_key_begin, r_keys, r_vals, r_used, r_default);
            r_prev <= r_default;
            r_n <= '0;
            r_ph <= '0;
            r_phase <= 2'd0;
            r_stat <= (i_command == CmdLookup) ? StDone
                    : ((i_key_begin >= i_key_end) ? StEmpty : StDone);
        end else if (i_cmd.build) begin
            if (c_vld && c_val != r_prev) begin
                if (r_n < TCntW'(Depth)) begin
                    r_tk[r_n[IdxW-1:0]] <= c_key;
                    r_tv[r_n[IdxW-1:0]] <= c_val;
                end
                if (r_n < TCntW'(TmpN)) r_n <= r_n + 1'b1;
                r_prev <= c_val;
            end
            if (last_ph) begin
                r_ph <= '0;
                r_phase <= r_phase + 2'd1;
            end else begin
                r_ph <= r_ph + 1'b1;
            end
        end else if (i_cmd.commit) begin
            if (r_n > TCntW'(Depth)) r_stat <= StFull;
        end
    end

    assign o_sts.is_lookup = (r_cmd == CmdLookup);
    assign o_sts.empty = (r_stat == StEmpty);
    assign o_sts.scan_done = (r_phase == 2'd3) && last_ph;
    assign o_lookup_value = (r_cmd == CmdLookup) ? r_res : '0;
    assign o_status = r_stat;
    assign o_entry_count = r_used;
endmodule
`default_nettype wire

### hw/rtl/interval_map_table.sv
// top level of the interval map table
//  channel  dir  tdata fields (low first)                       tuser
//  s_axis   in   key_begin[31:0] key_end[63:32] new_value[79:64]  command
//  m_axis   out  lookup_value[15:0] status[17:16] count[22:18]  -
//  cfg      in   default_value[15:0]                           -
// a lookup or an empty range goes from the build state straight to the output state;
// an assign first scans the table into the scratch table one entry a cycle, then
// passes through the commit state and the output state.
// the next word can be taken from the cycle after the result leaves.
// reset empties the table and clears the default; the result waits in its
// register while m_axis_tready is low and no new word is taken meanwhile.
`default_nettype none
module interval_map_table import imt_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [79:0]  s_axis_tdata,   // key_begin, key_end, new_value
    input  wire         s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // lookup_value, status, entry_count, pad
    input  wire         i_cfg_we,
    input  wire [15:0]  i_cfg_data
);
    t_cmd cmd;
    t_sts sts;
    logic [ValW-1:0] lv;
    logic [1:0] st;
    logic [CntW-1:0] cnt;

    imt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_fire(m_axis_tvalid && m_axis_tready),
        .i_sts(sts), .o_cmd(cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid)
    );

    imt_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_command(s_axis_tuser),
        .i_key_begin(s_axis_tdata[31:0]),
        .i_key_end(s_axis_tdata[63:32]),
        .i_new_value(s_axis_tdata[79:64]),
        .o_sts(sts), .o_lookup_value(lv), .o_status(st), .o_entry_count(cnt)
    );

    assign m_axis_tdata = {1'b0, cnt, st, lv};
endmodule
`default_nettype wire

### verif/tb_top.sv
// self-checking testbench for the interval map table
`default_nettype none
module tb_top;
    import imt_pkg::*;

    localparam int LIMIT = 2000000;

    typedef struct {
        logic       cmd;
        logic [31:0] kb;
        logic [31:0] ke;
        logic [15:0] val;
        logic       chk;
        logic [15:0] x_val;
        logic [1:0]  x_st;
        logic [4:0]  x_cnt;
    } t_row;

    typedef struct packed {
        logic [15:0] val;
        logic [1:0]  st;
        logic [4:0]  cnt;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    // predictor state
    logic [31:0] map_keys[Depth];
    logic [15:0] map_vals[Depth];
    int          map_used;
    logic [15:0] map_dflt;

    t_res result_q[$];
    int   errors = 0;
    int   cycles = 0;
    int   src_idle = 0;
    int   snk_stall = 0;
    bit   hold_off = 1'b0;

    interval_map_table dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [15:0] map_at(logic [31:0] k);
        logic [15:0] v;
        v = map_dflt;
        for (int i = 0; i < map_used; i++) begin
            if (map_keys[i] <= k) v = map_vals[i];
            else break;
        end
        return v;
    endfunction

    function automatic t_res predict_item(logic cmd, logic [31:0] kb, logic [31:0] ke,
                                          logic [15:0] val);
        t_res r;
        logic [31:0] nk[$];
        logic [15:0] nv[$];
        logic [15:0] prev, last;
        logic [31:0] pk[$];
        logic [15:0] pv[$];
        r = '0;
        if (cmd == CmdLookup) begin
            r.val = map_at(kb);
            r.st = StDone;
        end else if (kb >= ke) begin
            r.st = StEmpty;
        end else begin
            last = map_at(ke);
            for (int i = 0; i < map_used; i++)
                if (map_keys[i] < kb) begin pk.push_back(map_keys[i]); pv.push_back(map_vals[i]); end
            pk.push_back(kb); pv.push_back(val);
            pk.push_back(ke); pv.push_back(last);
            for (int i = 0; i < map_used; i++)
                if (map_keys[i] > ke) begin pk.push_back(map_keys[i]); pv.push_back(map_vals[i]); end
            prev = map_dflt;
            foreach (pk[i]) begin
                if (pv[i] != prev) begin nk.push_back(pk[i]); nv.push_back(pv[i]); end
                prev = pv[i];
            end
            if (nk.size() > Depth) begin
                r.st = StFull;
            end else begin
                r.st = StDone;
                map_used = nk.size();
                foreach (nk[i]) begin map_keys[i] = nk[i]; map_vals[i] = nv[i]; end
            end
        end
        r.cnt = map_used[4:0];
        return r;
    endfunction

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (result_q.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                errors++;
            end else begin
                t_res e;
                e = result_q.pop_front();
                if (m_axis_tdata[15:0] !== e.val) begin
                    $error("lookup_value exp %0d got %0d", e.val, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[17:16] !== e.st) begin
                    $error("status exp %0d got %0d", e.st, m_axis_tdata[17:16]);
                    errors++;
                end
                if (m_axis_tdata[22:18] !== e.cnt) begin
                    $error("entry_count exp %0d got %0d", e.cnt, m_axis_tdata[22:18]);
                    errors++;
                end
            end
        end
    end

    // receiver stall, long hold-off counted here
    int hold_cnt = 0;
    always @(posedge i_clk) begin
        if (hold_off && hold_cnt == 0) hold_cnt <= 400;
        if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic send_item(logic cmd, logic [31:0] kb, logic [31:0] ke, logic [15:0] val,
                             output t_res r);
        while ($urandom_range(99) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        r = predict_item(cmd, kb, ke, val);
        result_q.push_back(r);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {val, ke, kb};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_default(logic [15:0] d);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= d;
        map_dflt = d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_key(int span);
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(span);
            default: return $urandom_range(span);
        endcase
    endfunction

    t_row dir_rows[] = '{
        '{CmdLookup, 32'd0, 32'd0, 16'd0, 1, 16'd0, StDone, 5'd0},
        '{CmdAssign, 32'd5, 32'd5, 16'd7, 1, 16'd0, StEmpty, 5'd0},
        '{CmdAssign, 32'd9, 32'd3, 16'd7, 1, 16'd0, StEmpty, 5'd0},
        '{CmdAssign, 32'd10, 32'd20, 16'd0, 1, 16'd0, StDone, 5'd0},
        '{CmdAssign, 32'd10, 32'd20, 16'hFFFF, 1, 16'd0, StDone, 5'd2},
        '{CmdLookup, 32'd10, 32'd0, 16'd0, 1, 16'hFFFF, StDone, 5'd2},
        '{CmdLookup, 32'd20, 32'd0, 16'd0, 1, 16'd0, StDone, 5'd2},
        '{CmdAssign, 32'd0, 32'hFFFF_FFFF, 16'd3, 1, 16'd0, StDone, 5'd2},
        '{CmdLookup, 32'hFFFF_FFFF, 32'd0, 16'd0, 1, 16'd0, StDone, 5'd2},
        '{CmdAssign, 32'd20, 32'd30, 16'd3, 0, 0, 0, 0},
        '{CmdAssign, 32'd30, 32'd40, 16'd4, 0, 0, 0, 0},
        '{CmdAssign, 32'd15, 32'd35, 16'd9, 0, 0, 0, 0},
        '{CmdAssign, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h5555, 0, 0, 0, 0},
        '{CmdLookup, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0},
        '{CmdLookup, 32'd16, 32'hFFFF_FFFF, 16'hAAAA, 0, 0, 0, 0}
    };

    initial begin
        t_res r;
        int phase_idle[4] = '{0, 58, 0, 34};
        int phase_stall[4] = '{0, 0, 58, 34};
        logic [15:0] dflts[4] = '{16'hFFFF, 16'd0, 16'd3, 16'h1234};
        map_used = 0;
        map_dflt = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].cmd, dir_rows[i].kb, dir_rows[i].ke, dir_rows[i].val, r);
            if (dir_rows[i].chk) begin
                if (r.val !== dir_rows[i].x_val) begin
                    $error("row %0d lookup_value exp %0d got %0d", i, dir_rows[i].x_val, r.val);
                    errors++;
                end
                if (r.st !== dir_rows[i].x_st) begin
                    $error("row %0d status exp %0d got %0d", i, dir_rows[i].x_st, r.st);
                    errors++;
                end
                if (r.cnt !== dir_rows[i].x_cnt) begin
                    $error("row %0d entry_count exp %0d got %0d", i, dir_rows[i].x_cnt, r.cnt);
                    errors++;
                end
            end
        end
        // fill the table to overflow with alternating values
        for (int i = 0; i < 20; i++)
            send_item(CmdAssign, 32'(100 + 2 * i), 32'(101 + 2 * i), 16'(i + 1), r);
        // new default with live entries forces canonical rebuild
        set_default(16'd9);
        send_item(CmdAssign, 32'd5, 32'd6, 16'd1, r);
        for (int p = 0; p < 4; p++) begin
            set_default(dflts[p]);
            src_idle = phase_idle[p];
            snk_stall = phase_stall[p];
            if (p == 1) hold_off = 1'b1;
            for (int n = 0; n < 180; n++) begin
                logic [31:0] kb, ke;
                int span;
                span = ($urandom_range(3) == 0) ? 1000 : 40;
                kb = rand_key(span);
                ke = ($urandom_range(9) == 0) ? rand_key(span) : kb + $urandom_range(span);
                if (ke < kb && $urandom_range(1)) ke = 32'hFFFF_FFFF;
                send_item(1'($urandom_range(1)), kb, ke,
                          $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(4)), r);
                if (n == 5) hold_off = 1'b0;
                if (n == 90) drain();
            end
        end
        drain();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
